// File: design/cbo_pkg.sv
// Shared constants and helpers for the cylinder-versus-box overlap block.
// No dependencies; imported by cylinder_box_overlap_top.
package cbo_pkg;

   localparam int R_BITS     = 31;    // radius, height and depth width
   localparam int EPS_BITS   = 16;
   localparam int SQ_BITS    = 64;    // radicand width of the square root
   localparam int SQ_STEPS   = 32;    // one root bit per stage
   localparam int ROOT_BITS  = 32;

   localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd7;
   localparam logic [R_BITS-1:0]   DEPTH_MAX = 31'h7FFF_FFFF;

   // Side of the box that gives the smallest push when the axis is inside.
   localparam logic [1:0] SIDE_LEFT  = 2'd0;
   localparam logic [1:0] SIDE_RIGHT = 2'd1;
   localparam logic [1:0] SIDE_BACK  = 2'd2;
   localparam logic [1:0] SIDE_FRONT = 2'd3;

   // One step of the digit-by-digit square root: returns {remainder, root}.
   function automatic logic [2*SQ_BITS-1:0] isqrt_step(input logic [SQ_BITS-1:0] v,
                                                       input logic [SQ_BITS-1:0] root,
                                                       input logic [SQ_BITS-1:0] sbit);
      logic [SQ_BITS-1:0] t;
      t = root + sbit;
      if (v >= t) begin
         isqrt_step = {v - t, (root >> 1) + sbit};
      end else begin
         isqrt_step = {v, root >> 1};
      end
   endfunction

endpackage

// File: design/cylinder_box_overlap_top.sv
// Top level of the cylinder-versus-box overlap pipeline.
// Depends on cbo_pkg for widths, side codes and the square root step.
//
// Usage:
// A beat on the request channel is one cylinder/box pair. It is taken at a
// rising clock edge where start is high and busy is low. Busy is always low:
// the pipeline takes a new beat in every cycle and never stalls.
// Each beat yields exactly one response beat, shown for a single cycle with
// rsp_valid high, in request order. For the default Q16.16 the pipeline is made
// of setup registers for the clamp, magnitudes, squares and sum, a 32-stage
// square root with one root bit per stage, a setup register for the penetration,
// FRAC_BITS + 1 stages of a restoring divider that builds the unit normal one
// quotient bit a stage, and an output register.
// Throughput is one beat per cycle, set by the fully unrolled root and
// divider stages. The receiver cannot hold off responses, so there is no
// back-pressure anywhere.
// The csr port writes the inside-box distance threshold; write it only when
// no beat is in flight. Synchronous reset empties the pipeline valid bits and
// sets the threshold to 7; beats in flight at reset are dropped.
module cylinder_box_overlap_top
   import cbo_pkg::*;
#(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_cyl_center_x,
   input  logic signed [COORD_BITS-1:0] req_cyl_base_y,
   input  logic signed [COORD_BITS-1:0] req_cyl_center_z,
   input  logic        [R_BITS-1:0]     req_cyl_radius,
   input  logic        [R_BITS-1:0]     req_cyl_height,
   input  logic signed [COORD_BITS-1:0] req_box_min_x,
   input  logic signed [COORD_BITS-1:0] req_box_min_y,
   input  logic signed [COORD_BITS-1:0] req_box_min_z,
   input  logic signed [COORD_BITS-1:0] req_box_max_x,
   input  logic signed [COORD_BITS-1:0] req_box_max_y,
   input  logic signed [COORD_BITS-1:0] req_box_max_z,
   input  logic                         req_flip_normal,
   input  logic                         csr_we,
   input  logic        [EPS_BITS-1:0]   csr_wdata,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output logic signed [FRAC_BITS+1:0]  rsp_normal_x,
   output logic signed [FRAC_BITS+1:0]  rsp_normal_y,
   output logic signed [FRAC_BITS+1:0]  rsp_normal_z,
   output logic        [R_BITS-1:0]     rsp_depth
);

   localparam int CW  = (COORD_BITS > R_BITS) ? COORD_BITS : R_BITS;
   localparam int W   = CW + 3;                   // internal signed width
   localparam int NB  = FRAC_BITS + 2;            // normal width
   localparam int QB  = FRAC_BITS + 1;            // quotient bits
   localparam int DW  = ROOT_BITS + FRAC_BITS + 1;
   localparam int LAT = FRAC_BITS + 39;

   typedef struct packed {
      logic                ok;
      logic                flip;
      logic                ysgn;
      logic                sx;
      logic                sz;
      logic                axis_in;
      logic [1:0]          code;
      logic [R_BITS-1:0]   r;
      logic [R_BITS-1:0]   ax;
      logic [R_BITS-1:0]   az;
      logic signed [W-1:0] ovy;
      logic signed [W-1:0] m;
      logic signed [W-1:0] hpen;
   } side_type;

   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // Threshold register.
   logic [EPS_BITS-1:0] eps_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_we) begin
         eps_ff <= csr_wdata;
      end
   end

   // Stage 1: vertical overlap, clamp offsets and side distances.
   logic                s1_vld_ff;
   logic signed [W-1:0] s1_ovy_ff, s1_dx_ff, s1_dz_ff;
   logic signed [W-1:0] s1_left_ff, s1_right_ff, s1_back_ff, s1_front_ff;
   logic                s1_ysgn_ff, s1_flip_ff;
   logic [R_BITS-1:0]   s1_r_ff;

   logic signed [W-1:0] cx, by, cz, hh, mnx, mny, mnz, mxx, mxy, mxz;
   logic signed [W-1:0] top, lo_y, hi_y, clx, clz;
   logic signed [W-1:0] s1_ovy_in, s1_dx_in, s1_dz_in;
   logic                s1_ysgn_in;

   always_comb begin
      cx  = W'(req_cyl_center_x);
      by  = W'(req_cyl_base_y);
      cz  = W'(req_cyl_center_z);
      hh  = W'(req_cyl_height);
      mnx = W'(req_box_min_x);
      mny = W'(req_box_min_y);
      mnz = W'(req_box_min_z);
      mxx = W'(req_box_max_x);
      mxy = W'(req_box_max_y);
      mxz = W'(req_box_max_z);
      top  = by + hh;
      hi_y = (top < mxy) ? top : mxy;
      lo_y = (by > mny) ? by : mny;
      s1_ovy_in = hi_y - lo_y;
      clx = (cx < mnx) ? mnx : cx;
      clx = (clx > mxx) ? mxx : clx;
      clz = (cz < mnz) ? mnz : cz;
      clz = (clz > mxz) ? mxz : clz;
      s1_dx_in = cx - clx;
      s1_dz_in = cz - clz;
      s1_ysgn_in = ((by <<< 1) + hh) > (mny + mxy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_ovy_ff   <= s1_ovy_in;
      s1_dx_ff    <= s1_dx_in;
      s1_dz_ff    <= s1_dz_in;
      s1_left_ff  <= cx - mnx;
      s1_right_ff <= mxx - cx;
      s1_back_ff  <= cz - mnz;
      s1_front_ff <= mxz - cz;
      s1_ysgn_ff  <= s1_ysgn_in;
      s1_flip_ff  <= req_flip_normal;
      s1_r_ff     <= req_cyl_radius;
   end

   // Stage 2: gate on overlap and radius, magnitudes, smallest side push.
   logic     s2_vld_ff;
   side_type s2_side_ff, s2_side_in;
   logic signed [W-1:0] ax_full, az_full, r_s, m_sel;
   logic [1:0] code_sel;

   always_comb begin
      r_s = W'(s1_r_ff);
      ax_full = (s1_dx_ff < 0) ? -s1_dx_ff : s1_dx_ff;
      az_full = (s1_dz_ff < 0) ? -s1_dz_ff : s1_dz_ff;
      m_sel = s1_left_ff;
      code_sel = SIDE_LEFT;
      if (s1_right_ff < m_sel) begin
         m_sel = s1_right_ff;
         code_sel = SIDE_RIGHT;
      end
      if (s1_back_ff < m_sel) begin
         m_sel = s1_back_ff;
         code_sel = SIDE_BACK;
      end
      if (s1_front_ff < m_sel) begin
         m_sel = s1_front_ff;
         code_sel = SIDE_FRONT;
      end
      s2_side_in        = '0;
      s2_side_in.ok     = (s1_ovy_ff > 0) && (ax_full <= r_s) && (az_full <= r_s);
      s2_side_in.flip   = s1_flip_ff;
      s2_side_in.ysgn   = s1_ysgn_ff;
      s2_side_in.sx     = s1_dx_ff < 0;
      s2_side_in.sz     = s1_dz_ff < 0;
      s2_side_in.code   = code_sel;
      s2_side_in.r      = s1_r_ff;
      s2_side_in.ax     = ax_full[R_BITS-1:0];
      s2_side_in.az     = az_full[R_BITS-1:0];
      s2_side_in.ovy    = s1_ovy_ff;
      s2_side_in.m      = m_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_side_ff <= s2_side_in;
   end

   // Stage 3: squares.
   logic                  s3_vld_ff;
   side_type              s3_side_ff;
   logic [2*R_BITS-1:0]   s3_sqx_ff, s3_sqz_ff, s3_rsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_side_ff <= s2_side_ff;
      s3_sqx_ff  <= s2_side_ff.ax * s2_side_ff.ax;
      s3_sqz_ff  <= s2_side_ff.az * s2_side_ff.az;
      s3_rsq_ff  <= s2_side_ff.r * s2_side_ff.r;
   end

   // Stage 4 feeds the root: sum of squares and the radius test.
   logic               sq_vld_ff  [0:SQ_STEPS];
   side_type           sq_side_ff [0:SQ_STEPS];
   logic [SQ_BITS-1:0] sq_v_ff    [0:SQ_STEPS];
   logic [SQ_BITS-1:0] sq_root_ff [0:SQ_STEPS];
   logic [SQ_BITS-1:0] dsq;
   side_type           s4_side_in;

   always_comb begin
      dsq = SQ_BITS'(s3_sqx_ff) + SQ_BITS'(s3_sqz_ff);
      s4_side_in = s3_side_ff;
      s4_side_in.ok = s3_side_ff.ok && (dsq <= SQ_BITS'(s3_rsq_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SQ_STEPS; k++) begin
            sq_vld_ff[k] <= 1'b0;
         end
      end else begin
         sq_vld_ff[0] <= s3_vld_ff;
         for (int k = 0; k < SQ_STEPS; k++) begin
            sq_vld_ff[k+1] <= sq_vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      sq_v_ff[0]    <= dsq;
      sq_root_ff[0] <= '0;
      sq_side_ff[0] <= s4_side_in;
      for (int k = 0; k < SQ_STEPS; k++) begin
         {sq_v_ff[k+1], sq_root_ff[k+1]} <=
            isqrt_step(sq_v_ff[k], sq_root_ff[k], SQ_BITS'(1) << (62 - 2 * k));
         sq_side_ff[k+1] <= sq_side_ff[k];
      end
   end

   // Post-root stage: inside test, horizontal penetration, divider setup.
   logic [ROOT_BITS-1:0] root_dist;
   side_type             pr_side_in;
   logic signed [W-1:0]  r_w;

   logic                 dv_vld_ff  [0:QB];
   side_type             dv_side_ff [0:QB];
   logic [ROOT_BITS-1:0] dv_dist_ff [0:QB];
   logic [DW-1:0]        dv_rx_ff   [0:QB];
   logic [DW-1:0]        dv_rz_ff   [0:QB];
   logic [QB-1:0]        dv_qx_ff   [0:QB];
   logic [QB-1:0]        dv_qz_ff   [0:QB];

   always_comb begin
      root_dist = sq_root_ff[SQ_STEPS][ROOT_BITS-1:0];
      r_w  = W'(sq_side_ff[SQ_STEPS].r);
      pr_side_in = sq_side_ff[SQ_STEPS];
      pr_side_in.axis_in = root_dist <= ROOT_BITS'(eps_ff);
      pr_side_in.hpen = pr_side_in.axis_in ? (r_w + sq_side_ff[SQ_STEPS].m)
                                           : (r_w - W'(root_dist));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QB; k++) begin
            dv_vld_ff[k] <= 1'b0;
         end
      end else begin
         dv_vld_ff[0] <= sq_vld_ff[SQ_STEPS];
         for (int k = 0; k < QB; k++) begin
            dv_vld_ff[k+1] <= dv_vld_ff[k];
         end
      end
   end

   // Restoring divider: stage k decides quotient bit FRAC_BITS - k.
   always_ff @(posedge clock) begin
      logic [DW-1:0] dsh;
      dv_side_ff[0] <= pr_side_in;
      dv_dist_ff[0] <= root_dist;
      dv_rx_ff[0]   <= DW'(sq_side_ff[SQ_STEPS].ax) << FRAC_BITS;
      dv_rz_ff[0]   <= DW'(sq_side_ff[SQ_STEPS].az) << FRAC_BITS;
      dv_qx_ff[0]   <= '0;
      dv_qz_ff[0]   <= '0;
      for (int k = 0; k < QB; k++) begin
         dsh = DW'(dv_dist_ff[k]) << (FRAC_BITS - k);
         dv_side_ff[k+1] <= dv_side_ff[k];
         dv_dist_ff[k+1] <= dv_dist_ff[k];
         if (dv_rx_ff[k] >= dsh) begin
            dv_rx_ff[k+1] <= dv_rx_ff[k] - dsh;
            dv_qx_ff[k+1] <= dv_qx_ff[k] | (QB'(1) << (FRAC_BITS - k));
         end else begin
            dv_rx_ff[k+1] <= dv_rx_ff[k];
            dv_qx_ff[k+1] <= dv_qx_ff[k];
         end
         if (dv_rz_ff[k] >= dsh) begin
            dv_rz_ff[k+1] <= dv_rz_ff[k] - dsh;
            dv_qz_ff[k+1] <= dv_qz_ff[k] | (QB'(1) << (FRAC_BITS - k));
         end else begin
            dv_rz_ff[k+1] <= dv_rz_ff[k];
            dv_qz_ff[k+1] <= dv_qz_ff[k];
         end
      end
   end

   // Final stage: pick vertical or horizontal push, flip and saturate.
   side_type            fs;
   logic signed [NB-1:0] one_n, qxn, qzn, hx, hz, nx, ny, nz;
   logic signed [W-1:0]  pen, dmax;
   logic [R_BITS-1:0]    depth_in;

   always_comb begin
      fs    = dv_side_ff[QB];
      one_n = NB'(1) <<< FRAC_BITS;
      qxn   = NB'(dv_qx_ff[QB]);
      qzn   = NB'(dv_qz_ff[QB]);
      hx    = '0;
      hz    = '0;
      if (fs.axis_in) begin
         case (fs.code)
            SIDE_LEFT:  hx = -one_n;
            SIDE_RIGHT: hx = one_n;
            SIDE_BACK:  hz = -one_n;
            SIDE_FRONT: hz = one_n;
            default:    hx = '0;
         endcase
      end else begin
         hx = fs.sx ? -qxn : qxn;
         hz = fs.sz ? -qzn : qzn;
      end
      nx  = '0;
      ny  = '0;
      nz  = '0;
      pen = '0;
      if (fs.ok) begin
         if (fs.ovy < fs.hpen) begin
            ny  = fs.ysgn ? one_n : -one_n;
            pen = fs.ovy;
         end else begin
            nx  = hx;
            nz  = hz;
            pen = fs.hpen;
         end
      end
      if (fs.flip) begin
         nx = -nx;
         ny = -ny;
         nz = -nz;
      end
      dmax = W'(DEPTH_MAX);
      if (pen <= 0) begin
         depth_in = '0;
      end else if (pen > dmax) begin
         depth_in = DEPTH_MAX;
      end else begin
         depth_in = pen[R_BITS-1:0];
      end
   end

   logic out_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= dv_vld_ff[QB];
      end
   end

   logic                 out_hit_ff;
   logic signed [NB-1:0] out_nx_ff, out_ny_ff, out_nz_ff;
   logic [R_BITS-1:0]    out_depth_ff;
   always_ff @(posedge clock) begin
      out_hit_ff   <= depth_in != '0;
      out_nx_ff    <= nx;
      out_ny_ff    <= ny;
      out_nz_ff    <= nz;
      out_depth_ff <= depth_in;
   end

   assign rsp_valid    = out_vld_ff;
   assign rsp_hit      = out_hit_ff;
   assign rsp_normal_x = out_nx_ff;
   assign rsp_normal_y = out_ny_ff;
   assign rsp_normal_z = out_nz_ff;
   assign rsp_depth    = out_depth_ff;

`ifndef SYNTHESIS
   // Every accepted beat yields a response strobe.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid)
      else $error("response strobe does not match request latency");

   a_hit_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit == (rsp_depth != '0)))
      else $error("hit flag disagrees with depth");

   // A vertical push never carries a horizontal component.
   a_vertical: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_normal_y != '0) |-> (rsp_normal_x == '0 && rsp_normal_z == '0))
      else $error("vertical normal mixed with horizontal part");
`endif

endmodule
